// ===== rtl/core/scba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and codes of the size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    // configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int LIMIT_W     = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic REG_ARENA_BOUND = 1'b0;   // register index, paddr[2]

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic accept;   // request taken this cycle
        logic look;     // lookup step after accept: lookup of head or link word
        logic exec;     // commit state changes and load the result
    } cmd_t;

    typedef struct packed {
        logic out_blocked;  // result register full and receiver stalling
    } sts_t;

endpackage

// ===== rtl/core/scba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_ctrl
// Request sequencer: accept, look up, execute, one request at a time.
// ----------------------------------------------------------------------------
module scba_ctrl
    import scba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold until the result register can take the answer
                if (!sts.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd.accept = 1'b0;
        cmd.look   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_LOOK:
            begin
                cmd.look = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = !sts.out_blocked;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/scba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_datapath
// Class selection, free-stack heads, link memory, heap top and result register.
// ----------------------------------------------------------------------------
module scba_datapath
    import scba_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int NUM_CLASSES     = 13,
    parameter int MIN_BLOCK_BYTES = 16,
    parameter int ALIGN_BYTES     = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [LIMIT_W-1:0] arena_bound,
    input  logic               req_type,
    input  logic [15:0]        request_size,
    input  logic [15:0]        free_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        user_address,
    output logic [1:0]         status
);

    // ALIGN_BYTES and HEAP_BYTES are powers of two
    localparam int SHIFT       = $clog2(ALIGN_BYTES);
    localparam int BLOCK_COUNT = HEAP_BYTES / ALIGN_BYTES;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int HEAD_W      = $clog2(BLOCK_COUNT + 1);
    localparam int LINK_W      = $clog2(BLOCK_COUNT + NUM_CLASSES + 1);
    localparam int TOP_W       = $clog2(HEAP_BYTES + 1);
    localparam int K_W         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CLS_W       = $clog2((MIN_BLOCK_BYTES << (NUM_CLASSES - 1))
                                        + ALIGN_BYTES + 1);
    localparam int W0          = (TOP_W > CLS_W) ? TOP_W : CLS_W;
    localparam int W           = ((W0 > 18) ? W0 : 18) + 1;
    localparam int TAG_BASE    = BLOCK_COUNT + 1;

    function automatic logic [W-1:0] class_bytes(input logic [K_W-1:0] k);
        logic [W-1:0] raw;
        raw = W'(MIN_BLOCK_BYTES) << k;
        return (raw + W'(ALIGN_BYTES - 1)) & ~W'(ALIGN_BYTES - 1);
    endfunction

    // state
    logic [HEAD_W-1:0] head_reg [NUM_CLASSES];
    logic [LINK_W-1:0] link_mem [BLOCK_COUNT];
    logic [TOP_W-1:0]  bump_ptr_reg;

    // request context
    logic              is_free_reg;
    logic              oversize_reg;
    logic              addr_ok_reg;
    logic              tag_ok_reg;
    logic              fits_reg;
    logic              popped_reg;
    logic [K_W-1:0]    k_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TOP_W-1:0]  start_reg;
    logic [TOP_W-1:0]  end_reg;
    logic [HEAD_W-1:0] head_rd_reg;
    logic [LINK_W-1:0] link_rd_reg;

    // result register
    logic              out_valid_reg;
    logic [15:0]       user_address_reg;
    logic [1:0]        status_reg;

    // accept-cycle decode
    logic [W-1:0]      need;
    logic [K_W-1:0]    k_in;
    logic              found;
    logic [W-1:0]      fstart;
    logic              addr_ok_in;
    logic [IDX_W-1:0]  fidx_in;

    // lookup-cycle decode
    logic [W-1:0]      lim;
    logic              popped;
    logic [HEAD_W-1:0] head_m1;
    logic [IDX_W-1:0]  pop_idx;
    logic [W-1:0]      start;
    logic [W-1:0]      blk_end;
    logic [LINK_W-1:0] tag_off;
    logic              tag_ok;
    logic [K_W-1:0]    k_free;

    // head read port and link read port
    logic [K_W-1:0]    head_rd_k;
    logic [HEAD_W-1:0] head_sel;
    logic              head_rd_en;
    logic [IDX_W-1:0]  link_rd_idx;
    logic              link_rd_en;

    // commit
    logic              alloc_ok;
    logic              free_ok;
    logic              link_we;
    logic [LINK_W-1:0] link_wdata;

    always_comb
    begin
        need  = (W'(request_size) + W'(2 * ALIGN_BYTES - 1)) & ~W'(ALIGN_BYTES - 1);
        k_in  = '0;
        found = 1'b0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (need <= (W'(MIN_BLOCK_BYTES) << i))
            begin
                k_in  = K_W'(i);
                found = 1'b1;
            end
        end
    end

    assign fstart     = W'(free_address) - W'(ALIGN_BYTES);
    assign addr_ok_in = (W'(free_address) >= W'(ALIGN_BYTES))
                     && (free_address[SHIFT-1:0] == '0)
                     && (fstart < W'(bump_ptr_reg));
    assign fidx_in    = fstart[SHIFT +: IDX_W];

    assign lim     = (W'(arena_bound) < W'(HEAP_BYTES)) ? W'(arena_bound) : W'(HEAP_BYTES);
    assign popped  = (head_rd_reg != '0);
    assign head_m1 = head_rd_reg - HEAD_W'(1);
    assign pop_idx = head_m1[IDX_W-1:0];
    assign start   = popped ? (W'(pop_idx) << SHIFT) : W'(bump_ptr_reg);
    assign blk_end = start + class_bytes(k_reg);

    assign tag_off = link_rd_reg - LINK_W'(TAG_BASE);
    assign tag_ok  = (link_rd_reg >= LINK_W'(TAG_BASE))
                  && (tag_off < LINK_W'(NUM_CLASSES));
    assign k_free  = tag_off[K_W-1:0];

    // one head read per cycle, at the class chosen by the current step
    assign head_rd_k  = cmd.look ? k_free : k_in;
    assign head_rd_en = cmd.accept || (cmd.look && is_free_reg);

    always_comb
    begin
        head_sel = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (head_rd_k == K_W'(i))
            begin
                head_sel = head_reg[i];
            end
        end
    end

    assign link_rd_idx = cmd.accept ? fidx_in : pop_idx;
    assign link_rd_en  = cmd.accept || (cmd.look && !is_free_reg && popped);

    assign alloc_ok   = !is_free_reg && !oversize_reg && fits_reg;
    assign free_ok    = is_free_reg && addr_ok_reg && tag_ok_reg;
    assign link_we    = cmd.exec && (alloc_ok || free_ok);
    assign link_wdata = is_free_reg ? LINK_W'(head_rd_reg)
                                    : LINK_W'(TAG_BASE) + LINK_W'(k_reg);

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[idx_reg] <= link_wdata;
        end
        if (link_rd_en)
        begin
            link_rd_reg <= link_mem[link_rd_idx];
        end
    end

    // request context
    always_ff @(posedge clk)
    begin
        if (head_rd_en)
        begin
            head_rd_reg <= head_sel;
        end
        if (cmd.accept)
        begin
            is_free_reg  <= req_type;
            oversize_reg <= !found;
            addr_ok_reg  <= addr_ok_in;
            k_reg        <= k_in;
            idx_reg      <= fidx_in;
        end
        if (cmd.look)
        begin
            if (is_free_reg)
            begin
                tag_ok_reg <= tag_ok;
                k_reg      <= k_free;
            end
            else
            begin
                fits_reg   <= (blk_end <= lim);
                popped_reg <= popped;
                start_reg  <= start[TOP_W-1:0];
                end_reg    <= blk_end[TOP_W-1:0];
                idx_reg    <= popped ? pop_idx : start[SHIFT +: IDX_W];
            end
        end
    end

    // free-stack heads and heap top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_ptr_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (alloc_ok)
            begin
                if (popped_reg)
                begin
                    head_reg[k_reg] <= link_rd_reg[HEAD_W-1:0];
                end
                else
                begin
                    bump_ptr_reg <= end_reg;
                end
            end
            else if (free_ok)
            begin
                head_reg[k_reg] <= HEAD_W'(idx_reg) + HEAD_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            user_address_reg <= alloc_ok
                ? 16'(W'(start_reg) + W'(ALIGN_BYTES)) : 16'd0;
            if (is_free_reg)
            begin
                status_reg <= STATUS_OK;
            end
            else if (oversize_reg)
            begin
                status_reg <= STATUS_OVERSIZE;
            end
            else if (!fits_reg)
            begin
                status_reg <= STATUS_EXHAUSTED;
            end
            else
            begin
                status_reg <= STATUS_OK;
            end
        end
    end

    assign sts.out_blocked = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign user_address    = user_address_reg;
    assign status          = status_reg;

endmodule

// ===== rtl/core/size_class_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Power-of-two size-class heap allocator with per-class free stacks.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request: req_type selects
// allocate (request_size) or free (free_address). Output channel (out_valid /
// out_stall) returns one result per request: user_address and status.
// A request passes through accept (free-head and link reads issued), lookup
// (block start, limit check, pop link read or tag decode) and execute (link
// memory and head writes, result loaded), as the single-port link memory and
// one free-stack head's read-modify-write demand; a new request is taken the
// cycle after execute. The result register frees the sequencer: a new request
// is accepted while a result waits; if the receiver still stalls at the next
// execute, the block holds there with in_stall high. Reset empties all free
// stacks, clears the heap top and sets the heap bound register to 65536; the
// link memory is not cleared and needs no clearing pass. The bound register
// sits at APB address 0 and must be written only while idle; the user keeps
// to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int NUM_CLASSES     = 13,
    parameter int MIN_BLOCK_BYTES = 16,
    parameter int ALIGN_BYTES     = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [15:0]           request_size,
    input  logic [15:0]           free_address,
    // results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           user_address,
    output logic [1:0]            status
);

    logic [LIMIT_W-1:0] arena_bound_reg;
    logic               cfg_we;
    cmd_t               cmd;
    sts_t               sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_ARENA_BOUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_bound_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            arena_bound_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ARENA_BOUND) ? 32'(arena_bound_reg) : 32'd0;

    scba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    scba_datapath #(
        .HEAP_BYTES      (HEAP_BYTES),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .ALIGN_BYTES     (ALIGN_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .arena_bound  (arena_bound_reg),
        .req_type     (req_type),
        .request_size (request_size),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .user_address (user_address),
        .status       (status)
    );

endmodule

// ===== tb/size_class_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_allocator_tb
// Self-checking bench for the size-class block allocator. A shadow allocator
// predicts the address and status of every request; a queue-fed driver and
// a monitor move requests and results with random idling on both sides. The
// heap bound is rewritten between phases, including zero and its clamp.
// ----------------------------------------------------------------------------
module size_class_block_allocator_tb;
    import scba_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int HEAP_BYTES      = 65536;
    localparam int NUM_CLASSES     = 13;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int ALIGN_BYTES     = 8;
    localparam int BLOCK_COUNT     = HEAP_BYTES / ALIGN_BYTES;
    localparam int TAG_BASE        = BLOCK_COUNT + 1;
    localparam int STALL_PCT       = 34;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int FREED_KEEP      = 32;
    localparam logic [CFG_ADDR_W-1:0] ARENA_BOUND_ADDR = CFG_ADDR_W'(4 * REG_ARENA_BOUND);
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] request_size;
        logic [15:0] free_address;
    } request_t;

    typedef struct packed {
        logic [15:0] user_address;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        request_t req;
        result_t  res;
    } planned_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  req_type     = 1'b0;
    logic [15:0]           request_size = '0;
    logic [15:0]           free_address = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [15:0]           user_address;
    logic [1:0]            status;

    // shadow allocator state
    logic [13:0] class_head [NUM_CLASSES];
    logic [13:0] link_word [BLOCK_COUNT];
    bit          link_written [BLOCK_COUNT];
    logic [16:0] bump_ptr;
    logic [16:0] arena_bound;

    planned_t    pending_requests [$];
    result_t     awaiting_results [$];
    result_t     presented_result;
    logic [15:0] live_blocks [$];
    logic [15:0] freed_blocks [$];
    bit          steady       = 1'b0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    size_class_block_allocator #(
        .HEAP_BYTES      (HEAP_BYTES),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .ALIGN_BYTES     (ALIGN_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .request_size (request_size),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .user_address (user_address),
        .status       (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic result_t predict_request(request_t r);
        result_t res;
        int      need;
        int      csize;
        int      k;
        int      start;
        int      bytes;
        int      idx;
        int      lim;
        int      addr;
        int      tag;
        bit      popped;
        res = '0;
        if (r.req_type == REQ_ALLOC)
        begin
            need  = ((int'(r.request_size) + 2 * ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            csize = MIN_BLOCK_BYTES;
            k     = 0;
            while (csize < need && k < NUM_CLASSES)
            begin
                csize = csize << 1;
                k++;
            end
            if (k >= NUM_CLASSES)
                res.status = STATUS_OVERSIZE;
            else
            begin
                bytes  = ((csize + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                popped = (class_head[k] != 0);
                idx    = 0;
                if (popped)
                begin
                    idx   = (int'(class_head[k]) - 1) % BLOCK_COUNT;
                    start = idx * ALIGN_BYTES;
                end
                else
                    start = int'(bump_ptr);
                lim = (int'(arena_bound) > HEAP_BYTES) ? HEAP_BYTES : int'(arena_bound);
                // the whole block must end inside the limit, popped or cut
                if (start + bytes > lim)
                    res.status = STATUS_EXHAUSTED;
                else
                begin
                    if (popped)
                        class_head[k] = link_word[idx];
                    else
                    begin
                        idx      = (start / ALIGN_BYTES) % BLOCK_COUNT;
                        bump_ptr = 17'(start + bytes);
                    end
                    link_word[idx]    = 14'(TAG_BASE + k);
                    link_written[idx] = 1'b1;
                    res.user_address  = 16'(start + ALIGN_BYTES);
                end
            end
        end
        else
        begin
            addr = int'(r.free_address);
            if (addr >= ALIGN_BYTES && addr % ALIGN_BYTES == 0
                && addr - ALIGN_BYTES < int'(bump_ptr))
            begin
                idx = (addr - ALIGN_BYTES) / ALIGN_BYTES;
                tag = int'(link_word[idx]) - TAG_BASE;
                // only a live class tag gets pushed; free links and junk drop
                if (tag >= 0 && tag < NUM_CLASSES)
                begin
                    link_word[idx]    = class_head[tag];
                    class_head[tag]   = 14'(idx + 1);
                    link_written[idx] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // a free that reaches the link memory must hit a word written before
    function automatic bit free_reads_written(int addr);
        return !(addr >= ALIGN_BYTES && addr % ALIGN_BYTES == 0
                 && addr - ALIGN_BYTES < int'(bump_ptr))
               || link_written[(addr - ALIGN_BYTES) / ALIGN_BYTES];
    endfunction

    function automatic result_t queue_request(logic kind, int size, int addr);
        request_t r;
        result_t  res;
        int       i;
        r.req_type     = kind;
        r.request_size = 16'(size);
        r.free_address = 16'(addr);
        res = predict_request(r);
        pending_requests.push_back('{r, res});
        if (kind == REQ_ALLOC && res.status == STATUS_OK)
        begin
            live_blocks.push_back(res.user_address);
            for (i = freed_blocks.size() - 1; i >= 0; i--)
                if (freed_blocks[i] == res.user_address)
                    freed_blocks.delete(i);
        end
        else if (kind == REQ_FREE)
        begin
            for (i = live_blocks.size() - 1; i >= 0; i--)
                if (live_blocks[i] == r.free_address)
                begin
                    live_blocks.delete(i);
                    freed_blocks.push_back(r.free_address);
                end
            if (freed_blocks.size() > FREED_KEEP)
                void'(freed_blocks.pop_front());
        end
        return res;
    endfunction

    function automatic logic [15:0] send_alloc(int size);
        result_t res;
        res = queue_request(REQ_ALLOC, size, $urandom);
        return res.user_address;
    endfunction

    function automatic void send_free(int addr);
        void'(queue_request(REQ_FREE, $urandom, addr));
    endfunction

    task automatic run_random(int count);
        int n;
        int pick;
        int size_pick;
        int addr;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                void'(send_alloc($urandom_range(0, 65535)));
            else if (pick < 54 || live_blocks.size() == 0)
            begin
                size_pick = $urandom_range(0, 99);
                if (size_pick < 70)
                    void'(send_alloc($urandom_range(0, 120)));
                else if (size_pick < 93)
                    void'(send_alloc($urandom_range(121, 1000)));
                else
                    void'(send_alloc($urandom_range(1001, 8000)));
            end
            else if (pick < 86)
                send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            else if (pick < 93 && freed_blocks.size() != 0)
                send_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
            else
            begin
                addr = $urandom_range(0, 65535);
                // misalign any address that would land on an unwritten link word
                if (!free_reads_written(addr))
                    addr = addr | 1;
                send_free(addr);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || awaiting_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_arena_bound(logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ARENA_BOUND_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {15'd0, value[LIMIT_W-1:0]})
        begin
            mismatches++;
            $display("%0t: arena_bound readback expected %0d, got %0d",
                     $time, value[LIMIT_W-1:0], prdata);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        arena_bound = value[LIMIT_W-1:0];
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        planned_t next_item;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            req_type     <= 1'b0;
            request_size <= '0;
            free_address <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaiting_results.push_back(presented_result);
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0
                    && (steady || $urandom_range(0, 99) >= STALL_PCT))
                begin
                    next_item        = pending_requests.pop_front();
                    presented_result = next_item.res;
                    in_valid         <= 1'b1;
                    req_type         <= next_item.req.req_type;
                    request_size     <= next_item.req.request_size;
                    free_address     <= next_item.req.free_address;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t expected;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaiting_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got address %0d status %0d",
                             $time, user_address, status);
                end
                else
                begin
                    expected = awaiting_results.pop_front();
                    if (user_address !== expected.user_address)
                    begin
                        mismatches++;
                        $display("%0t: user_address expected %0d, got %0d",
                                 $time, expected.user_address, user_address);
                    end
                    if (status !== expected.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, expected.status, status);
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [15:0] big_block;
        logic [15:0] tiny_a;
        logic [15:0] tiny_b;
        logic [15:0] pair_block;
        int          i;
        for (i = 0; i < NUM_CLASSES; i++)
            class_head[i] = '0;
        for (i = 0; i < BLOCK_COUNT; i++)
        begin
            link_word[i]    = '0;
            link_written[i] = 1'b0;
        end
        bump_ptr    = '0;
        arena_bound = LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_arena_bound(32'h0001_0000);
        big_block  = send_alloc(32760);     // half the heap, cut at address zero
        tiny_a     = send_alloc(0);         // header alone, smallest class
        tiny_b     = send_alloc(8);         // header plus size fills the smallest class
        pair_block = send_alloc(9);         // spills into the next class
        void'(send_alloc(65528));           // largest class, end past the limit
        void'(send_alloc(65529));           // no class holds it
        void'(send_alloc(65535));
        send_free(0);                       // below the header size
        send_free(int'(tiny_a) + 4);        // misaligned
        send_free(65528);                   // past the heap top
        send_free(int'(bump_ptr) + ALIGN_BYTES);
        send_free(big_block);
        send_free(big_block);               // double free
        void'(send_alloc(20000));           // pop the big block back
        send_free(tiny_a);
        send_free(tiny_b);
        void'(send_alloc(1));               // pop the last block pushed
        void'(send_alloc(100));
        send_free(pair_block);
        wait_idle();

        write_arena_bound(32'h0);
        void'(send_alloc(9));               // popped block, end past the limit
        void'(send_alloc(0));
        void'(send_alloc(3000));            // heap top past the limit
        send_free(live_blocks[0]);
        wait_idle();

        write_arena_bound(32'h0001_0000);
        run_random(200);
        wait_idle();

        // long stretch with both sides running flat out
        write_arena_bound($urandom_range(int'(bump_ptr), HEAP_BYTES));
        steady = 1'b1;
        run_random(150);
        wait_idle();
        steady = 1'b0;

        write_arena_bound(32'hFFFF_FFFF);
        run_random(200);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += awaiting_results.size();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
